### src/rgb10a2_unpack_rescale_macros.svh
// ----------------------------------------------------------------------------
// rgb10a2 unpack/rescale assertion macros
// shared concurrent assertion forms, clocked on clk_i and quiet in reset
// ----------------------------------------------------------------------------
`ifndef RGB10A2_UNPACK_RESCALE_MACROS_SVH
`define RGB10A2_UNPACK_RESCALE_MACROS_SVH

// same-cycle implication
`define RGBU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RGBU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rgbu_pkg.sv
// ----------------------------------------------------------------------------
// rgbu_pkg
// types, constants and helpers for the rgb10a2 unpack/rescale block
// ----------------------------------------------------------------------------
package rgbu_pkg;

  localparam int unsigned COLOR_W  = 10;
  localparam int unsigned CHAN_W   = 16;
  localparam int unsigned DEPTH_W  = 5;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned LATENCY  = 4;
  localparam int unsigned SCALED_W = 27;
  localparam int unsigned PROD_W   = 55;
  localparam int unsigned RECIP_SH = 37;

  // floor(2^37 / 1023), quotient estimate is low by at most one
  localparam logic [27:0] RECIP_K = 28'((64'd1 << RECIP_SH) / 64'd1023);
  localparam logic [9:0]  DIVISOR = 10'd1023;
  localparam logic [9:0]  HALF_DIV = 10'd511;
  // a two-bit alpha times 341 lands on the ten-bit colour scale exactly
  localparam logic [8:0]  ALPHA_SPREAD = 9'd341;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd10;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 5'd16;

  typedef enum logic [0:0] {
    REG_BIT_DEPTH   = 1'b0,
    REG_PREMULTIPLY = 1'b1
  } cfg_reg_e;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [2:0] color3_t;

  function automatic chan_t depth_to_max(input logic [DEPTH_W-1:0] d);
    logic [CHAN_W:0] full;
    full = '0;
    if (d > DEPTH_MAX) begin
      full = {1'b0, {CHAN_W{1'b1}}};
    end else begin
      full = (17'd1 << d) - 17'd1;
    end
    return full[CHAN_W-1:0];
  endfunction

endpackage

### src/rgb10a2_unpack_rescale.sv
// ----------------------------------------------------------------------------
// rgb10a2_unpack_rescale
// unpacks a 10:10:10:2 pixel word and rescales each channel to bit_depth
// ----------------------------------------------------------------------------
// usage:
//   drive pixel_word_i and raise start for one cycle per word; busy is
//   always low, so a word can be taken on every clock edge.
//   the four channels appear on red_o/green_o/blue_o/alpha_o with valid_o
//   high for exactly one cycle; each taken word reaches them through the
//   four register stages: scale multiply, reciprocal multiply, remainder
//   fix, premultiply. throughput is one word per cycle.
//   bit_depth (index 0) and premultiply (index 1) are written through
//   cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must write them only while
//   no word is in flight, as the block itself does not enforce this.
//   reset clears the valid pipeline and returns bit_depth to 10 and
//   premultiply to 0. the receiver cannot stall: each result is shown
//   for one cycle only.
// ----------------------------------------------------------------------------
module rgb10a2_unpack_rescale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [rgbu_pkg::WORD_W-1:0] pixel_word_i,
  input  logic                        cfg_we_i,
  input  rgbu_pkg::cfg_reg_e          cfg_idx_i,
  input  logic [rgbu_pkg::CFG_W-1:0]  cfg_wdata_i,
  output logic                        valid_o,
  output rgbu_pkg::chan_t             red_o,
  output rgbu_pkg::chan_t             green_o,
  output rgbu_pkg::chan_t             blue_o,
  output rgbu_pkg::chan_t             alpha_o
);
  import rgbu_pkg::*;
  `include "rgb10a2_unpack_rescale_macros.svh"

  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               premul_q, premul_d;
  chan_t              max_q, max_d;
  logic [LATENCY-1:0] valid_q, valid_d;
  logic               take;
  logic [COLOR_W-1:0] alpha_ext;
  color3_t            scaled;
  chan_t              alpha_scaled;
  color3_t            color_out;

  assign busy = 1'b0;
  assign take = start & ~busy;

  always_comb begin
    depth_d  = depth_q;
    premul_d = premul_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BIT_DEPTH:   depth_d  = cfg_wdata_i[DEPTH_W-1:0];
        REG_PREMULTIPLY: premul_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
    max_d   = depth_to_max(depth_d);
    valid_d = {valid_q[LATENCY-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= DEPTH_RESET;
      premul_q <= 1'b0;
      max_q    <= depth_to_max(DEPTH_RESET);
      valid_q  <= '0;
    end else begin
      depth_q  <= depth_d;
      premul_q <= premul_d;
      max_q    <= max_d;
      valid_q  <= valid_d;
    end
  end

  assign alpha_ext = COLOR_W'(pixel_word_i[31:30]) * COLOR_W'(ALPHA_SPREAD);

  rgbu_lane u_lane_r (
    .clk_i    (clk_i),
    .value_i  (pixel_word_i[9:0]),
    .max_i    (max_q),
    .scaled_o (scaled[0])
  );

  rgbu_lane u_lane_g (
    .clk_i    (clk_i),
    .value_i  (pixel_word_i[19:10]),
    .max_i    (max_q),
    .scaled_o (scaled[1])
  );

  rgbu_lane u_lane_b (
    .clk_i    (clk_i),
    .value_i  (pixel_word_i[29:20]),
    .max_i    (max_q),
    .scaled_o (scaled[2])
  );

  rgbu_lane u_lane_a (
    .clk_i    (clk_i),
    .value_i  (alpha_ext),
    .max_i    (max_q),
    .scaled_o (alpha_scaled)
  );

  rgbu_premul u_premul (
    .clk_i         (clk_i),
    .premultiply_i (premul_q),
    .color_i       (scaled),
    .alpha_i       (alpha_scaled),
    .color_o       (color_out),
    .alpha_o       (alpha_o)
  );

  assign red_o   = color_out[0];
  assign green_o = color_out[1];
  assign blue_o  = color_out[2];
  assign valid_o = valid_q[LATENCY-1];

  `RGBU_ASSERT_NEXT(a_take_enters, take, valid_q[0], "taken word not in pipeline")
  `RGBU_ASSERT_NOW(a_out_from_start, valid_o, $past(start, LATENCY), "result without word")
  `RGBU_ASSERT_NOW(a_plain_range, valid_o && !premul_q,
                   red_o <= max_q && green_o <= max_q && blue_o <= max_q && alpha_o <= max_q,
                   "channel above max")
  `RGBU_ASSERT_NOW(a_premul_range, valid_o && premul_q,
                   alpha_o <= 16'd255 && red_o <= alpha_o && green_o <= alpha_o &&
                   blue_o <= alpha_o, "premultiplied channel above alpha")

endmodule

### src/rgbu_lane.sv
// ----------------------------------------------------------------------------
// rgbu_lane
// three-stage rescale of one 10-bit value: round(c * max / 1023)
// ----------------------------------------------------------------------------
module rgbu_lane (
  input  logic                          clk_i,
  input  logic [rgbu_pkg::COLOR_W-1:0]  value_i,
  input  rgbu_pkg::chan_t               max_i,
  output rgbu_pkg::chan_t               scaled_o
);
  import rgbu_pkg::*;

  logic [SCALED_W-1:0] y_d, y_q, y2_q;
  logic [PROD_W-1:0]   prod_d, prod_q;
  chan_t               q0;
  logic [SCALED_W-1:0] rem;
  logic [CHAN_W:0]     q_inc;
  chan_t               res_d, res_q;

  // stage 1: c*M plus half the divisor
  assign y_d = SCALED_W'(value_i) * SCALED_W'(max_i) + SCALED_W'(HALF_DIV);

  // stage 2: reciprocal multiply
  assign prod_d = PROD_W'(y_q) * PROD_W'(RECIP_K);

  // stage 3: remainder check fixes the low estimate
  always_comb begin
    q0    = prod_q[RECIP_SH+CHAN_W-1:RECIP_SH];
    rem   = y2_q - (SCALED_W'({q0, 10'b0}) - SCALED_W'(q0));
    q_inc = {1'b0, q0} + 17'd1;
    res_d = (rem >= SCALED_W'(DIVISOR)) ? q_inc[CHAN_W-1:0] : q0;
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    prod_q <= prod_d;
    y2_q   <= y_q;
    res_q  <= res_d;
  end

  assign scaled_o = res_q;

endmodule

### src/rgbu_premul.sv
// ----------------------------------------------------------------------------
// rgbu_premul
// output stage: optional 8-bit saturate and alpha premultiply
// ----------------------------------------------------------------------------
module rgbu_premul (
  input  logic              clk_i,
  input  logic              premultiply_i,
  input  rgbu_pkg::color3_t color_i,
  input  rgbu_pkg::chan_t   alpha_i,
  output rgbu_pkg::color3_t color_o,
  output rgbu_pkg::chan_t   alpha_o
);
  import rgbu_pkg::*;

  color3_t    color_d, color_q;
  chan_t      alpha_d, alpha_q;
  logic [7:0] a8;
  logic [7:0] c8;
  logic [15:0] prod;
  logic [15:0] sum;

  always_comb begin
    a8      = (alpha_i > 16'd255) ? 8'hFF : alpha_i[7:0];
    color_d = color_i;
    alpha_d = alpha_i;
    c8      = '0;
    prod    = '0;
    sum     = '0;
    if (premultiply_i) begin
      alpha_d = {8'b0, a8};
      for (int i = 0; i < 3; i++) begin
        c8   = (color_i[i] > 16'd255) ? 8'hFF : color_i[i][7:0];
        prod = {8'b0, c8} * {8'b0, a8};
        // exact floor(p / 255) for any product of two bytes
        sum  = prod + {8'b0, prod[15:8]} + 16'd1;
        color_d[i] = {8'b0, sum[15:8]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
    alpha_q <= alpha_d;
  end

  assign color_o = color_q;
  assign alpha_o = alpha_q;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: rgb10a2 unpack/rescale testbench
// walks a table of directed pixel words over the depth and premultiply corner
// settings, then streams random words through several register settings and
// sender idle rates; each result is checked by table row or local predictor
// ----------------------------------------------------------------------------
module tb_top;
  import rgbu_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned N_DIRECTED     = 23;
  localparam int unsigned N_PHASES       = 10;
  localparam int unsigned PHASE_WORDS    = 150;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } rgba_out_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               premul;
    logic [WORD_W-1:0]  word;
    logic               typed;
    rgba_out_t          exp;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [WORD_W-1:0]    pixel_word_i;
  logic                 cfg_we_i;
  cfg_reg_e             cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 valid_o;
  chan_t                red_o;
  chan_t                green_o;
  chan_t                blue_o;
  chan_t                alpha_o;

  rgb10a2_unpack_rescale uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .pixel_word_i (pixel_word_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .valid_o      (valid_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o)
  );

  // register copies seen by the predictor, updated on accepted writes
  logic [DEPTH_W-1:0] model_depth;
  logic               model_premul;
  // register copies tracked by the stimulus side
  logic [DEPTH_W-1:0] drv_depth;
  logic               drv_premul;

  rgba_out_t   pending_pixels[$];
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  logic        next_typed;
  rgba_out_t   next_exp;

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{5'd10, 1'b0, 32'h0000_0000, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}},
    '{5'd10, 1'b0, 32'hFFFF_FFFF, 1'b1, '{16'd1023, 16'd1023, 16'd1023, 16'd1023}},
    '{5'd10, 1'b0, 32'h4000_03FF, 1'b1, '{16'd1023, 16'd0, 16'd0, 16'd341}},
    '{5'd10, 1'b0, 32'h800F_FC00, 1'b1, '{16'd0, 16'd1023, 16'd0, 16'd682}},
    '{5'd10, 1'b0, 32'hFFF0_0000, 1'b1, '{16'd0, 16'd0, 16'd1023, 16'd1023}},
    '{5'd10, 1'b0, 32'h2AAA_AAAA, 1'b0, '0},
    '{5'd16, 1'b0, 32'hFFFF_FFFF, 1'b1, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}},
    '{5'd16, 1'b0, 32'h5555_5555, 1'b0, '0},
    // depth above sixteen clips to the full 16-bit range
    '{5'd31, 1'b0, 32'hFFFF_FFFF, 1'b1, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}},
    '{5'd31, 1'b0, 32'h9ABC_DEF1, 1'b0, '0},
    // zero depth gives a zero maximum
    '{5'd0,  1'b0, 32'hFFFF_FFFF, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}},
    '{5'd0,  1'b0, 32'h1234_5678, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}},
    '{5'd1,  1'b0, 32'hFFFF_FFFF, 1'b1, '{16'd1, 16'd1, 16'd1, 16'd1}},
    '{5'd7,  1'b0, 32'h3FF0_03FF, 1'b0, '0},
    '{5'd8,  1'b1, 32'hFFFF_FFFF, 1'b1, '{16'd255, 16'd255, 16'd255, 16'd255}},
    '{5'd8,  1'b1, 32'h3FFF_FFFF, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}},
    '{5'd8,  1'b1, 32'h7FFF_FFFF, 1'b1, '{16'd85, 16'd85, 16'd85, 16'd85}},
    '{5'd8,  1'b1, 32'hBFF0_03FF, 1'b0, '0},
    // premultiply above eight bits saturates before the multiply
    '{5'd16, 1'b1, 32'hFFFF_FFFF, 1'b1, '{16'd255, 16'd255, 16'd255, 16'd255}},
    '{5'd16, 1'b1, 32'h4010_0401, 1'b0, '0},
    '{5'd31, 1'b1, 32'hC000_0000, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd255}},
    '{5'd0,  1'b1, 32'hFFFF_FFFF, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}},
    '{5'd10, 1'b0, 32'h0000_0000, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}}
  };

  function automatic int unsigned sat_byte(input int unsigned v);
    return (v > 255) ? 255 : v;
  endfunction

  function automatic rgba_out_t rescale_pixel(input logic [WORD_W-1:0] w,
                                              input logic [DEPTH_W-1:0] depth,
                                              input logic premul);
    int unsigned d;
    int unsigned m;
    int unsigned ch [3];
    int unsigned a;
    rgba_out_t   res;
    d = (depth > 16) ? 16 : depth;
    m = (32'd1 << d) - 1;
    for (int i = 0; i < 3; i++) begin
      ch[i] = (2 * int'(w[10*i +: COLOR_W]) * m + 1023) / 2046;
    end
    a = (2 * int'(w[31:30]) * m + 3) / 6;
    if (premul) begin
      a = sat_byte(a);
      for (int i = 0; i < 3; i++) begin
        ch[i] = (sat_byte(ch[i]) * a) / 255;
      end
    end
    res.red   = ch[0][CHAN_W-1:0];
    res.green = ch[1][CHAN_W-1:0];
    res.blue  = ch[2][CHAN_W-1:0];
    res.alpha = a[CHAN_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string name, input chan_t exp_v, input chan_t act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor, scoreboard and watchdog
  always @(posedge clk_i) begin
    rgba_out_t exp_px;
    rgba_out_t got_px;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BIT_DEPTH:   model_depth  = cfg_wdata_i[DEPTH_W-1:0];
          REG_PREMULTIPLY: model_premul = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (next_typed) begin
          pending_pixels.push_back(next_exp);
        end else begin
          pending_pixels.push_back(rescale_pixel(pixel_word_i, model_depth, model_premul));
        end
      end
      if (valid_o) begin
        got_px = '{red_o, green_o, blue_o, alpha_o};
        if (pending_pixels.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result word, expected none actual %h", $time, got_px);
        end else begin
          exp_px = pending_pixels.pop_front();
          check_field("red", exp_px.red, got_px.red);
          check_field("green", exp_px.green, got_px.green);
          check_field("blue", exp_px.blue, got_px.blue);
          check_field("alpha", exp_px.alpha, got_px.alpha);
        end
      end
      if ((start && !busy) || valid_o || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  task automatic send_word(input logic [WORD_W-1:0] w, input int unsigned idle_pct,
                           input logic typed, input rgba_out_t exp_px);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start        <= 1'b0;
      pixel_word_i <= $urandom;
    end
    @(negedge clk_i);
    next_typed   = typed;
    next_exp     = exp_px;
    start        <= 1'b1;
    pixel_word_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // stop sending and wait until every result word is back
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic apply_config(input logic [DEPTH_W-1:0] depth, input logic premul);
    settle();
    write_reg(REG_BIT_DEPTH, depth);
    // upper bits of the mode write are don't-care
    write_reg(REG_PREMULTIPLY, {CFG_W'($urandom_range(15)) << 1} | CFG_W'(premul));
    drv_depth  = depth;
    drv_premul = premul;
  endtask

  function automatic logic [COLOR_W-1:0] pick_colour();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom_range(1023));
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    if ($urandom_range(99) < 70) begin
      return $urandom;
    end
    return {2'($urandom_range(3)), pick_colour(), pick_colour(), pick_colour()};
  endfunction

  initial begin
    logic [DEPTH_W-1:0] ph_depth [N_PHASES];
    logic               ph_premul [N_PHASES];
    int unsigned        idle_rates [3];
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    pixel_word_i   = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_BIT_DEPTH;
    cfg_wdata_i    = '0;
    model_depth    = DEPTH_RESET;
    model_premul   = 1'b0;
    drv_depth      = DEPTH_RESET;
    drv_premul     = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    next_typed     = 1'b0;
    next_exp       = '0;
    ph_depth  = '{5'd8, 5'd16, 5'd8, 5'd31, 5'd0, 5'd13, 5'd16, 5'd10,
                  DEPTH_W'($urandom_range(31)), DEPTH_W'($urandom_range(16, 8))};
    ph_premul = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
                  1'($urandom_range(1)), 1'($urandom_range(1))};
    idle_rates = '{0, 66, 25};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].depth != drv_depth || directed_rows[i].premul != drv_premul) begin
        apply_config(directed_rows[i].depth, directed_rows[i].premul);
      end
      send_word(directed_rows[i].word, 0, directed_rows[i].typed, directed_rows[i].exp);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      apply_config(ph_depth[p], ph_premul[p]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(random_word(), idle_rates[p % 3], 1'b0, '0);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
